[hw/rtl/lor_pkg.sv]
// Label overlap remapper: shared types and constants.
// Used by every module of the block; has no dependencies of its own.
package lor_pkg;

  localparam int unsigned LABEL_W   = 4;  // label field width
  localparam int unsigned CFG_W     = 5;  // width of each count register
  localparam int unsigned REG_IDX_W = 1;  // configuration register index width
  localparam int unsigned MAP_LBL   = 16; // labels a 4-bit field can reach

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_CUR_COUNT  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_PREV_COUNT = 1'd1;

  // Input word kinds (carried on tuser)
  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_MAP   = 1'b1;

  typedef enum logic [2:0] {
    ST_RUN,    // streaming count and map words
    ST_DRAIN,  // last count word finishing its write
    ST_WALK,   // reading every counter for the argmax
    ST_FLUSH,  // final compare, counters cleared
    ST_DONE    // done word waiting for the output register
  } lor_state_e;

  // One step of the table walk, aligned with the memory read data
  typedef struct packed {
    logic               vld;
    logic               first;    // first column of a row
    logic               last;     // last column of a row
    logic               row_act;  // row takes part in the argmax
    logic               col_ok;   // column below the previous label count
    logic [LABEL_W-1:0] row;
    logic [LABEL_W-1:0] col;
  } lor_step_t;

  // Write into the label map
  typedef struct packed {
    logic               en;
    logic [LABEL_W-1:0] idx;
    logic [LABEL_W-1:0] val;
  } lor_map_wr_t;

endpackage

[hw/rtl/label_overlap_remapper.sv]
// Label overlap remapper, top level: control, forwarding, label map, output word.
// Instantiates lor_pair_mem and lor_argmax; uses lor_pkg.
//
//  channel  | dir | fields (lowest bit first)                     | accepted when
//  ---------+-----+-----------------------------------------------+---------------------
//  s_axis   | in  | tdata: cur_label[3:0] prev_label[7:4];        | tvalid & tready
//           |     | tuser: cmd; tlast: last                       |
//  m_axis   | out | tdata: mapped_label[3:0], zero pad; tuser:    | tvalid & tready
//           |     | done_res                                      |
//  cfg      | in  | idx 0 cur_count, idx 1 prev_count, data[4:0]  | cfg_we_i
//
// Count and map words go in at one per cycle; a map word's result sits in the
// output register in the cycle after acceptance. Counts use a read-modify-write
// through the counter memory with the previous write forwarded.
// A count word marked last stops input while it finishes its write, the argmax walk
// makes L*L memory reads (L = min(MAX_LABELS,16)), the walk closes and the done
// word is loaded. Stalls come only from m_axis_tready.
// Reset clears all counters at once through per-entry valid bits and sets the
// label map to identity; there is no clearing pass.
module label_overlap_remapper #(
  parameter int unsigned MAX_LABELS = 16,
  parameter int unsigned COUNT_BITS = 22
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // cur_label[3:0], prev_label[7:4]
  input  logic                          s_axis_tuser,   // cmd
  input  logic                          s_axis_tlast,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // mapped_label[3:0], zero pad
  output logic                          m_axis_tuser,   // done_res
  // configuration
  input  logic                          cfg_we_i,
  input  logic [lor_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [lor_pkg::CFG_W-1:0]     cfg_data_i
);
  import lor_pkg::*;

  // usable labels: a 4-bit field never reaches beyond 16
  localparam int unsigned LBL = (MAX_LABELS < MAP_LBL) ? MAX_LABELS : MAP_LBL;
  localparam int unsigned IW  = $clog2(LBL);
  localparam int unsigned AW  = 2 * IW;
  localparam logic [IW-1:0] LAST_IDX = IW'(LBL - 1);

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] cur_cnt_q, prev_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_cnt_q  <= CFG_W'(1);
      prev_cnt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CUR_COUNT:  cur_cnt_q  <= cfg_data_i;
        REG_PREV_COUNT: prev_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- input word ----------------
  logic [LABEL_W-1:0] in_cur, in_prev;
  logic               in_cmd, accept, in_range;

  assign in_cur  = s_axis_tdata[LABEL_W-1:0];
  assign in_prev = s_axis_tdata[2*LABEL_W-1:LABEL_W];
  assign in_cmd  = s_axis_tuser;
  assign accept  = s_axis_tvalid && s_axis_tready;

  // pair counted only if both labels fall inside both counts and the table
  assign in_range = ({1'b0, in_cur}  < cur_cnt_q)  && ({1'b0, in_cur}  < CFG_W'(LBL)) &&
                    ({1'b0, in_prev} < prev_cnt_q) && ({1'b0, in_prev} < CFG_W'(LBL));

  // ---------------- state ----------------
  lor_state_e          state_q, state_d;
  logic                s1_v_q, s1_v_d;       // count update stage
  logic [AW-1:0]       s1_addr_q, s1_addr_d;
  logic                s1_fwd_q, s1_fwd_d;   // memory data stale: use fwd_q
  logic [COUNT_BITS-1:0] fwd_q, fwd_d;
  logic [IW-1:0]       wi_q, wi_d, wj_q, wj_d;
  lor_step_t           step_q, step_d;
  logic                out_v_q, out_v_d;
  logic [LABEL_W-1:0]  out_lbl_q, out_lbl_d;
  logic                out_done_q, out_done_d;
  logic [LABEL_W-1:0]  map_q [LBL];

  logic [AW-1:0]         in_addr, rd_addr;
  logic [COUNT_BITS-1:0] rd_data, old_cnt, new_cnt;
  logic                  clr_all, out_free;
  logic [LABEL_W-1:0]    map_rd;
  lor_map_wr_t           map_wr;

  assign in_addr  = {in_cur[IW-1:0], in_prev[IW-1:0]};
  assign rd_addr  = (state_q == ST_WALK) ? {wi_q, wj_q} : in_addr;
  assign out_free = !out_v_q || m_axis_tready;

  // saturating increment of the stage-one counter
  assign old_cnt = s1_fwd_q ? fwd_q : rd_data;
  assign new_cnt = (&old_cnt) ? old_cnt : old_cnt + COUNT_BITS'(1);

  assign map_rd = ({1'b0, in_cur} < CFG_W'(LBL)) ? map_q[in_cur[IW-1:0]] : in_cur;

  assign s_axis_tready = (state_q == ST_RUN) && out_free;

  always_comb begin
    state_d    = state_q;
    s1_v_d     = 1'b0;
    s1_addr_d  = in_addr;
    s1_fwd_d   = 1'b0;
    fwd_d      = new_cnt;
    wi_d       = wi_q;
    wj_d       = wj_q;
    step_d     = '0;
    clr_all    = 1'b0;
    out_v_d    = out_v_q && !m_axis_tready;
    out_lbl_d  = out_lbl_q;
    out_done_d = out_done_q;

    unique case (state_q)
      ST_RUN: begin
        if (accept) begin
          if (in_cmd == CMD_MAP) begin
            out_v_d    = 1'b1;
            out_lbl_d  = map_rd;
            out_done_d = 1'b0;
          end else begin
            s1_v_d   = in_range;
            s1_fwd_d = in_range && s1_v_q && (s1_addr_q == in_addr);
            if (s_axis_tlast) begin
              state_d = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        wi_d    = '0;
        wj_d    = '0;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        step_d.vld     = 1'b1;
        step_d.first   = (wj_q == '0);
        step_d.last    = (wj_q == LAST_IDX);
        step_d.row_act = (prev_cnt_q != '0) && (CFG_W'(wi_q) < cur_cnt_q);
        step_d.col_ok  = CFG_W'(wj_q) < prev_cnt_q;
        step_d.row     = LABEL_W'(wi_q);
        step_d.col     = LABEL_W'(wj_q);
        if (wj_q == LAST_IDX) begin
          wj_d = '0;
          if (wi_q == LAST_IDX) begin
            state_d = ST_FLUSH;
          end else begin
            wi_d = wi_q + IW'(1);
          end
        end else begin
          wj_d = wj_q + IW'(1);
        end
      end
      ST_FLUSH: begin
        clr_all = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_lbl_d  = '0;
          out_done_d = 1'b1;
          state_d    = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_RUN;
      s1_v_q   <= 1'b0;
      s1_fwd_q <= 1'b0;
      wi_q     <= '0;
      wj_q     <= '0;
      step_q   <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_v_q   <= s1_v_d;
      s1_fwd_q <= s1_fwd_d;
      wi_q     <= wi_d;
      wj_q     <= wj_d;
      step_q   <= step_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q  <= s1_addr_d;
    fwd_q      <= fwd_d;
    out_lbl_q  <= out_lbl_d;
    out_done_q <= out_done_d;
  end

  // label map, identity after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LBL; k++) begin
        map_q[k] <= LABEL_W'(k);
      end
    end else if (map_wr.en) begin
      map_q[map_wr.idx[IW-1:0]] <= map_wr.val;
    end
  end

  lor_pair_mem #(
    .AW (AW),
    .DW (COUNT_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .wr_en_i   (s1_v_q),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (new_cnt),
    .clr_all_i (clr_all),
    .rd_data_o (rd_data)
  );

  lor_argmax #(
    .COUNT_BITS (COUNT_BITS)
  ) u_argmax (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step_q),
    .rd_data_i (rd_data),
    .map_wr_o  (map_wr)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(8 - LABEL_W){1'b0}}, out_lbl_q};
  assign m_axis_tuser  = out_done_q;

  // ---------------- assertions ----------------
  // the last count write lands before the walk reads the memory
  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> !s1_v_q)
    else $error("counter write during table walk");

  // forwarding only ever pairs with a pending update
  a_fwd_with_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fwd_q |-> s1_v_q)
    else $error("forward flag without count update");

  // label map changes only at the end of a walked row
  a_map_wr_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_wr.en |-> (state_q == ST_WALK || state_q == ST_FLUSH))
    else $error("label map written outside the walk");

  // walk steps follow walk cycles
  a_step_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q.vld |-> $past(state_q == ST_WALK))
    else $error("walk step without walk cycle");

  // after the flush the block moves to the done state with no walk step left
  a_done_after_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |=> (state_q == ST_DONE) && !step_q.vld)
    else $error("walk did not close cleanly");

endmodule

[hw/rtl/lor_pair_mem.sv]
// Label overlap remapper: pair counter memory, registered read.
// Per-entry valid bits stand in for a clear; depends on lor_pkg only by house rule.
module lor_pair_mem #(
  parameter int unsigned AW = 8,
  parameter int unsigned DW = 22
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          clr_all_i,
  output logic [DW-1:0] rd_data_o
);
  import lor_pkg::*;

  localparam int unsigned DEPTH = 1 << AW;

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [DW-1:0]    rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rdata_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[rd_addr_i];
      if (clr_all_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  // never-written entries read as zero
  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

[hw/rtl/lor_argmax.sv]
// Label overlap remapper: running argmax over each counter row of the walk.
// Takes walk steps and memory read data; emits label map writes. Uses lor_pkg.
module lor_argmax #(
  parameter int unsigned COUNT_BITS = 22
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lor_pkg::lor_step_t      step_i,
  input  logic [COUNT_BITS-1:0]   rd_data_i,
  output lor_pkg::lor_map_wr_t    map_wr_o
);
  import lor_pkg::*;

  logic [COUNT_BITS-1:0] top_q, top_d;
  logic [LABEL_W-1:0]    best_q, best_d;
  logic                  take;

  // strict compare: lowest column keeps a tie
  always_comb begin
    take   = step_i.first || (step_i.col_ok && (rd_data_i > top_q));
    top_d  = take ? rd_data_i  : top_q;
    best_d = take ? step_i.col : best_q;
    map_wr_o.en  = step_i.vld && step_i.last;
    map_wr_o.idx = step_i.row;
    map_wr_o.val = step_i.row_act ? best_d : step_i.row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= '0;
      best_q <= '0;
    end else if (step_i.vld) begin
      top_q  <= top_d;
      best_q <= best_d;
    end
  end

endmodule
